// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the keyboard barcode assembler.
// No dependencies; files that check their logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ----- rtl/hkba_pkg.sv -----
// Shared types, constants and keymap lookup for the keyboard barcode assembler.
// No dependencies; imported by every module of the block.
package hkba_pkg;

  // Scan buffer size; a scan holds at most BUFFER_BYTES-1 characters
  localparam int BUFFER_BYTES = 256;
  localparam logic [7:0] CHAR_LIMIT = 8'(BUFFER_BYTES - 1);

  localparam int KEY_SLOTS   = 8;
  localparam int SLOT_W      = $clog2(KEY_SLOTS);
  localparam int KEYMAP_SIZE = 57;
  localparam int FIRST_SLOT_BYTE = 2;

  localparam logic [7:0] SHIFT_MASK = 8'h22;

  // Character codes
  localparam logic [6:0] CH_NONE  = 7'h00;
  localparam logic [6:0] CH_CR    = 7'h0D;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_DEL   = 7'h7F;
  localparam logic [6:0] CH_SLASH = 7'h2F;
  localparam logic [6:0] CH_SEMI  = 7'h3B;
  localparam logic [6:0] CH_COLON = 7'h3A;

  // Keycodes that differ on the German layout
  localparam logic [7:0] KC_Y      = 8'd28;
  localparam logic [7:0] KC_Z      = 8'd29;
  localparam logic [7:0] KC_7      = 8'd36;
  localparam logic [7:0] KC_COMMA  = 8'd54;
  localparam logic [7:0] KC_PERIOD = 8'd55;

  // US keymap, unshifted column
  localparam logic [6:0] KEYMAP_PLAIN [0:KEYMAP_SIZE-1] = '{
    7'h00, 7'h00, 7'h00, 7'h00,
    7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67, 7'h68, 7'h69,
    7'h6A, 7'h6B, 7'h6C, 7'h6D, 7'h6E, 7'h6F, 7'h70, 7'h71, 7'h72,
    7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7A,
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
    7'h0D, 7'h00, 7'h08, 7'h00, 7'h20,
    7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C, 7'h5C, 7'h3B, 7'h27, 7'h60,
    7'h2C, 7'h2E, 7'h2F
  };

  // US keymap, shifted column
  localparam logic [6:0] KEYMAP_SHIFT [0:KEYMAP_SIZE-1] = '{
    7'h00, 7'h00, 7'h00, 7'h00,
    7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49,
    7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52,
    7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A,
    7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
    7'h0D, 7'h00, 7'h00, 7'h00, 7'h20,
    7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C, 7'h7C, 7'h3A, 7'h22, 7'h7E,
    7'h3C, 7'h3E, 7'h3F
  };

  typedef enum logic [1:0] {
    KIND_SKIP  = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_ENTER = 2'd2
  } key_kind_t;

  // One classified key slot
  typedef struct packed {
    key_kind_t  kind;
    logic [6:0] ch;
  } slot_t;

  typedef slot_t [KEY_SLOTS-1:0] report_t;

  // One result word
  typedef struct packed {
    logic [6:0] character;
    logic       scan_end;
    logic [7:0] scan_length;
    logic       last;
  } result_t;

  // Map a keycode to a character and sort it into skip, printable or Enter
  function automatic slot_t classify(logic [7:0] kc, logic shift, logic german);
    logic [7:0] kc_map;
    logic [6:0] ch;
    slot_t      s;
    kc_map = kc;
    if (german && kc == KC_Y) begin
      kc_map = KC_Z;
    end else if (german && kc == KC_Z) begin
      kc_map = KC_Y;
    end
    if (kc >= 8'(KEYMAP_SIZE)) begin
      ch = CH_NONE;
    end else if (shift) begin
      ch = KEYMAP_SHIFT[kc_map[5:0]];
    end else begin
      ch = KEYMAP_PLAIN[kc_map[5:0]];
    end
    // German shifted overrides
    if (german && shift) begin
      if (kc == KC_7) begin
        ch = CH_SLASH;
      end else if (kc == KC_COMMA) begin
        ch = CH_SEMI;
      end else if (kc == KC_PERIOD) begin
        ch = CH_COLON;
      end
    end
    s.ch = ch;
    if (ch == CH_CR) begin
      s.kind = KIND_ENTER;
    end else if (ch >= CH_SPACE && ch < CH_DEL) begin
      s.kind = KIND_CHAR;
    end else begin
      s.kind = KIND_SKIP;
    end
    return s;
  endfunction

endpackage

// ----- rtl/hid_keyboard_barcode_assembler.sv -----
// Keyboard barcode assembler: HID boot keyboard reports in, barcode characters out.
// Top level; depends on hkba_pkg, hkba_front, hkba_back and hkba_out_fifo.
//
// Input channel: one report word (modifiers, report_bytes, key_a..key_h) is taken
// at a clock edge with push high and full low. A two-deep report queue sits
// behind it, so reports are taken while the previous one is still being worked.
// Result channel: while empty is low the oldest result word is on character,
// scan_end, scan_length and last; pop with empty low takes it. A report gives
// zero to eight words; last marks the final word of a report.
// Holding: a word is held in the back end until the next word of its report or
// the report's last slot is reached, then is pushed when the result queue has room.
// Slot walk: the back end walks the eight key slots one per cycle while a report
// is queued and the walker is not held; a report without results still has all
// eight slots walked.
// Stalls: with the result queue full the walker holds at a result slot while a word
// is pending; the report queue fills, full rises, and nothing is dropped.
// Configuration: cfg_write loads cfg_data into the layout select (1 = German);
// write it only while the block is idle.
// Reset (rst, synchronous): queues empty, scan count zero, German layout.

module hid_keyboard_barcode_assembler
  import hkba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] modifiers,
  input  logic [3:0] report_bytes,
  input  logic [7:0] key_a,
  input  logic [7:0] key_b,
  input  logic [7:0] key_c,
  input  logic [7:0] key_d,
  input  logic [7:0] key_e,
  input  logic [7:0] key_f,
  input  logic [7:0] key_g,
  input  logic [7:0] key_h,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] character,
  output logic       scan_end,
  output logic [7:0] scan_length,
  output logic       last
);

  logic    layout_german;
  logic    rq_valid;
  report_t rq_report;
  logic    rq_pop;
  logic    res_push;
  result_t res_word;
  logic    res_full;
  result_t out_word;

  // Layout select register
  always_ff @(posedge clk) begin
    if (rst) begin
      layout_german <= 1'b1;
    end else if (cfg_write) begin
      layout_german <= cfg_data;
    end
  end

  hkba_front u_front (
    .clk           (clk),
    .rst           (rst),
    .layout_german (layout_german),
    .push          (push),
    .full          (full),
    .modifiers     (modifiers),
    .report_bytes  (report_bytes),
    .key_a         (key_a),
    .key_b         (key_b),
    .key_c         (key_c),
    .key_d         (key_d),
    .key_e         (key_e),
    .key_f         (key_f),
    .key_g         (key_g),
    .key_h         (key_h),
    .rq_valid      (rq_valid),
    .rq_report     (rq_report),
    .rq_pop        (rq_pop)
  );

  hkba_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rq_valid  (rq_valid),
    .rq_report (rq_report),
    .rq_pop    (rq_pop),
    .res_push  (res_push),
    .res_word  (res_word),
    .res_full  (res_full)
  );

  hkba_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_push  (res_push),
    .wr_word  (res_word),
    .wr_full  (res_full),
    .rd_empty (empty),
    .rd_pop   (pop),
    .rd_word  (out_word)
  );

  assign character   = out_word.character;
  assign scan_end    = out_word.scan_end;
  assign scan_length = out_word.scan_length;
  assign last        = out_word.last;

endmodule

// ----- rtl/hkba_front.sv -----
// Front end: accepts a report, classifies its key slots, queues it for the back end.
// Depends on hkba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hkba_front
  import hkba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       layout_german,
  input  logic       push,
  output logic       full,
  input  logic [7:0] modifiers,
  input  logic [3:0] report_bytes,
  input  logic [7:0] key_a,
  input  logic [7:0] key_b,
  input  logic [7:0] key_c,
  input  logic [7:0] key_d,
  input  logic [7:0] key_e,
  input  logic [7:0] key_f,
  input  logic [7:0] key_g,
  input  logic [7:0] key_h,
  output logic       rq_valid,
  output report_t    rq_report,
  input  logic       rq_pop
);

  localparam int RQ_DEPTH = 2;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  logic [7:0]          keys [KEY_SLOTS];
  logic                shift;
  report_t             classified;
  report_t             rq_mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr;
  logic [RQ_PTR_W-1:0] rd_ptr;
  logic [RQ_CNT_W-1:0] cnt;
  logic                wr_en;
  logic                rd_en;

  assign keys[0] = key_a;
  assign keys[1] = key_b;
  assign keys[2] = key_c;
  assign keys[3] = key_d;
  assign keys[4] = key_e;
  assign keys[5] = key_f;
  assign keys[6] = key_g;
  assign keys[7] = key_h;

  assign shift = (modifiers & SHIFT_MASK) != 8'h00;

  // Classify every slot; slots at or past the report length are skipped
  always_comb begin
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (report_bytes > 4'(j + FIRST_SLOT_BYTE)) begin
        classified[j] = classify(keys[j], shift, layout_german);
      end else begin
        classified[j] = '{kind: KIND_SKIP, ch: CH_NONE};
      end
    end
  end

  // Report queue
  assign full      = cnt == RQ_CNT_W'(RQ_DEPTH);
  assign rq_valid  = cnt != '0;
  assign rq_report = rq_mem[rd_ptr];
  assign wr_en     = push && !full;
  assign rd_en     = rq_pop && rq_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rq_mem[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      cnt <= cnt + RQ_CNT_W'(wr_en) - RQ_CNT_W'(rd_en);
    end
  end

  `ASSERT_NEVER(a_rq_over, clk, rst, cnt > RQ_CNT_W'(RQ_DEPTH), "report queue overflow")
  `ASSERT_NEVER(a_rq_under, clk, rst, rq_pop && cnt == '0, "pop from empty report queue")

endmodule

// ----- rtl/hkba_back.sv -----
// Back end: walks the queued key slots one per cycle unless held, keeps the scan count, builds results.
// Depends on hkba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hkba_back
  import hkba_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    rq_valid,
  input  report_t rq_report,
  output logic    rq_pop,
  output logic    res_push,
  output result_t res_word,
  input  logic    res_full
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(KEY_SLOTS - 1);

  logic [SLOT_W-1:0] idx;
  logic [7:0]        count;
  slot_t             slot;
  logic              take_char;
  logic              take_enter;
  logic              res;
  logic              can_push;
  logic              advance;
  logic              end_slot;
  result_t           new_word;

  // One result held back until it is known whether it ends its report
  result_t           pend;
  logic              p_valid;
  logic              p_final;

  assign slot       = rq_report[idx];
  assign take_char  = slot.kind == KIND_CHAR && count < CHAR_LIMIT;
  assign take_enter = slot.kind == KIND_ENTER && count != 8'd0;
  assign res        = rq_valid && (take_char || take_enter);
  assign can_push   = p_valid && !res_full;
  assign advance    = rq_valid && (!res || !p_valid || can_push);
  assign end_slot   = idx == LAST_SLOT;
  assign rq_pop     = advance && end_slot;
  assign res_push   = can_push && (p_final || (advance && res));

  always_comb begin
    res_word      = pend;
    res_word.last = p_final;
  end

  // Result for the current slot
  always_comb begin
    if (take_enter) begin
      new_word = '{character: CH_NONE, scan_end: 1'b1, scan_length: count, last: 1'b0};
    end else begin
      new_word = '{character: slot.ch, scan_end: 1'b0, scan_length: 8'd0, last: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res) begin
      pend <= new_word;
    end
  end

  // Slot walker, scan count and pending control
  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      count   <= '0;
      p_valid <= 1'b0;
      p_final <= 1'b0;
    end else begin
      if (advance) begin
        idx <= end_slot ? '0 : idx + 1'b1;
        if (take_char) begin
          count <= count + 8'd1;
        end else if (take_enter) begin
          count <= 8'd0;
        end
      end
      priority if (advance && res) begin
        p_valid <= 1'b1;
        p_final <= end_slot;
      end else if (res_push) begin
        p_valid <= 1'b0;
        p_final <= 1'b0;
      end else if (advance && end_slot && p_valid) begin
        p_final <= 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_final_valid, clk, rst, p_final && !p_valid, "final flag without pending word")
  `ASSERT_ALWAYS(a_enter_clear, clk, rst, advance && take_enter |=> count == 8'd0,
                 "count not cleared after end marker")

endmodule

// ----- rtl/hkba_out_fifo.sv -----
// Result queue between the back end and the result ports.
// Depends on hkba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hkba_out_fifo
  import hkba_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_push,
  input  result_t wr_word,
  output logic    wr_full,
  output logic    rd_empty,
  input  logic    rd_pop,
  output result_t rd_word
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             wr_en;
  logic             rd_en;

  assign wr_full  = cnt == CNT_W'(DEPTH);
  assign rd_empty = cnt == '0;
  assign rd_word  = mem[rd_ptr];
  assign wr_en    = wr_push && !wr_full;
  assign rd_en    = rd_pop && !rd_empty;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      cnt <= cnt + CNT_W'(wr_en) - CNT_W'(rd_en);
    end
  end

  `ASSERT_NEVER(a_push_full, clk, rst, wr_push && wr_full, "result word pushed while full")
  `ASSERT_NEVER(a_cnt_range, clk, rst, cnt > CNT_W'(DEPTH), "result queue count out of range")

endmodule

// ----- test/tb.sv -----
// Testbench for hid_keyboard_barcode_assembler: directed and random keyboard reports.
// Predicts every result word in SystemVerilog and checks it; needs only the block's RTL.
// Standalone: no files, no arguments.

module tb;

  // Keycodes used by the stimulus and the key decoder
  localparam logic [7:0] KC_A       = 8'd4;
  localparam logic [7:0] KC_B       = 8'd5;
  localparam logic [7:0] KC_X       = 8'd27;
  localparam logic [7:0] KC_Y       = 8'd28;
  localparam logic [7:0] KC_Z       = 8'd29;
  localparam logic [7:0] KC_1       = 8'd30;
  localparam logic [7:0] KC_7       = 8'd36;
  localparam logic [7:0] KC_0       = 8'd39;
  localparam logic [7:0] KC_ENTER   = 8'd40;
  localparam logic [7:0] KC_ESC     = 8'd41;
  localparam logic [7:0] KC_BKSP    = 8'd42;
  localparam logic [7:0] KC_TAB     = 8'd43;
  localparam logic [7:0] KC_SPACE   = 8'd44;
  localparam logic [7:0] KC_MINUS   = 8'd45;
  localparam logic [7:0] KC_RBRACE  = 8'd48;
  localparam logic [7:0] KC_BSLASH  = 8'd49;
  localparam logic [7:0] KC_COMMA   = 8'd54;
  localparam logic [7:0] KC_PERIOD  = 8'd55;
  localparam logic [7:0] KC_SLASH   = 8'd56;
  localparam logic [7:0] KEYMAP_END = 8'd57;

  // Character codes
  localparam logic [6:0] ASCII_NUL     = 7'h00;
  localparam logic [6:0] ASCII_CR      = 7'h0D;
  localparam logic [6:0] ASCII_SPACE   = 7'h20;
  localparam logic [6:0] ASCII_DEL     = 7'h7F;
  localparam logic [6:0] ASCII_SLASH   = 7'h2F;
  localparam logic [6:0] ASCII_SEMI    = 7'h3B;
  localparam logic [6:0] ASCII_COLON   = 7'h3A;
  localparam logic [6:0] ASCII_UPPER_A = 7'h41;
  localparam logic [6:0] ASCII_LOWER_A = 7'h61;

  localparam logic [7:0] SHIFT_KEYS       = 8'h22;
  localparam int         SCAN_BUFFER      = 256;
  localparam logic [7:0] SCAN_LIMIT       = 8'(SCAN_BUFFER - 1);
  localparam int         KEY_SLOTS        = 8;
  localparam int         FIRST_KEY_BYTE   = 2;
  localparam int         MAX_REPORT_BYTES = 10;
  localparam int         DRAIN_CYCLES     = 64;
  localparam int         CYCLE_LIMIT      = 400000;

  localparam logic LAYOUT_US     = 1'b0;
  localparam logic LAYOUT_GERMAN = 1'b1;

  typedef struct packed {
    logic [7:0]      mods;
    logic [3:0]      nbytes;
    logic [7:0][7:0] keys;   // keys[0] is key_a
  } report_t;

  typedef struct packed {
    logic [6:0] character;
    logic       scan_end;
    logic [7:0] scan_length;
    logic       last;
  } scan_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_data = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] modifiers = '0;
  logic [3:0] report_bytes = '0;
  logic [7:0] key_a = '0, key_b = '0, key_c = '0, key_d = '0;
  logic [7:0] key_e = '0, key_f = '0, key_g = '0, key_h = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [6:0] character;
  logic       scan_end;
  logic [7:0] scan_length;
  logic       last;

  // Keymap columns that are not simple ranges
  logic [6:0] digit_plain [10] = '{7'h31, 7'h32, 7'h33, 7'h34, 7'h35,
                                   7'h36, 7'h37, 7'h38, 7'h39, 7'h30};
  logic [6:0] digit_shift [10] = '{7'h21, 7'h40, 7'h23, 7'h24, 7'h25,
                                   7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29};
  logic [6:0] punct_plain [12] = '{7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C, 7'h5C,
                                   7'h3B, 7'h27, 7'h60, 7'h2C, 7'h2E, 7'h2F};
  logic [6:0] punct_shift [12] = '{7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C, 7'h7C,
                                   7'h3A, 7'h22, 7'h7E, 7'h3C, 7'h3E, 7'h3F};

  // Predictor state
  logic       layout_german = LAYOUT_GERMAN;
  logic [7:0] scan_count = '0;
  scan_word_t scan_words [$];

  int unsigned push_idle_pct = 0;
  int unsigned pop_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  hid_keyboard_barcode_assembler dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .push(push), .full(full), .modifiers(modifiers), .report_bytes(report_bytes),
    .key_a(key_a), .key_b(key_b), .key_c(key_c), .key_d(key_d),
    .key_e(key_e), .key_f(key_f), .key_g(key_g), .key_h(key_h),
    .empty(empty), .pop(pop), .character(character), .scan_end(scan_end),
    .scan_length(scan_length), .last(last)
  );

  always #1 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random pop
  always @(posedge clk) begin
    pop <= ($urandom_range(0, 99) >= pop_idle_pct);
  end

  // Check every popped word against the oldest predicted one
  always @(posedge clk) begin : check_words
    scan_word_t want;
    if (!rst && pop && !empty) begin
      if (scan_words.size() == 0) begin
        $error("unexpected word: character %0h scan_end %0d scan_length %0d last %0d",
               character, scan_end, scan_length, last);
        mismatches++;
      end else begin
        want = scan_words.pop_front();
        if (character !== want.character) begin
          $error("character: expected %0h, got %0h", want.character, character);
          mismatches++;
        end
        if (scan_end !== want.scan_end) begin
          $error("scan_end: expected %0d, got %0d", want.scan_end, scan_end);
          mismatches++;
        end
        if (scan_length !== want.scan_length) begin
          $error("scan_length: expected %0d, got %0d", want.scan_length, scan_length);
          mismatches++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          mismatches++;
        end
      end
    end
  end

  // Keycode to ASCII; escape, backspace and tab give nothing printable
  function automatic logic [6:0] key_char(input logic [7:0] kc, input logic shifted,
                                          input logic german);
    logic [7:0] code;
    code = kc;
    if (german && kc == KC_Y) code = KC_Z;
    else if (german && kc == KC_Z) code = KC_Y;
    if (german && shifted && kc == KC_7) return ASCII_SLASH;
    if (german && shifted && kc == KC_COMMA) return ASCII_SEMI;
    if (german && shifted && kc == KC_PERIOD) return ASCII_COLON;
    if (code >= KC_A && code <= KC_Z)
      return 7'((shifted ? ASCII_UPPER_A : ASCII_LOWER_A) + code - KC_A);
    if (code >= KC_1 && code <= KC_0)
      return shifted ? digit_shift[code - KC_1] : digit_plain[code - KC_1];
    if (code == KC_ENTER) return ASCII_CR;
    if (code == KC_SPACE) return ASCII_SPACE;
    if (code >= KC_MINUS && code < KEYMAP_END)
      return shifted ? punct_shift[code - KC_MINUS] : punct_plain[code - KC_MINUS];
    return ASCII_NUL;
  endfunction

  // Turn one accepted report into the words it must produce
  task automatic assemble_report(input report_t r);
    int unsigned nbytes, pos;
    logic        shifted;
    logic [6:0]  ch;
    scan_word_t  w;
    scan_word_t  words [$];
    nbytes = (r.nbytes > MAX_REPORT_BYTES) ? MAX_REPORT_BYTES : r.nbytes;
    shifted = |(r.mods & SHIFT_KEYS);
    for (pos = FIRST_KEY_BYTE; pos < nbytes; pos++) begin
      ch = key_char(r.keys[pos - FIRST_KEY_BYTE], shifted, layout_german);
      if (ch == ASCII_CR) begin
        // Enter closes the scan, but only a nonempty one
        if (scan_count != 0) begin
          words.push_back('{character: ASCII_NUL, scan_end: 1'b1,
                            scan_length: scan_count, last: 1'b0});
          scan_count = '0;
        end
      end else if (ch >= ASCII_SPACE && ch < ASCII_DEL) begin
        // Printable characters beyond the buffer are dropped
        if (scan_count < SCAN_LIMIT) begin
          words.push_back('{character: ch, scan_end: 1'b0, scan_length: 8'd0,
                            last: 1'b0});
          scan_count++;
        end
      end
    end
    if (words.size() != 0) begin
      w = words.pop_back();
      w.last = 1'b1;
      words.push_back(w);
    end
    foreach (words[i]) scan_words.push_back(words[i]);
  endtask

  // Send one report and predict its words once accepted
  task automatic send_report(input report_t r);
    while ($urandom_range(0, 99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    modifiers <= r.mods;
    report_bytes <= r.nbytes;
    key_a <= r.keys[0];
    key_b <= r.keys[1];
    key_c <= r.keys[2];
    key_d <= r.keys[3];
    key_e <= r.keys[4];
    key_f <= r.keys[5];
    key_g <= r.keys[6];
    key_h <= r.keys[7];
    @(posedge clk);
    while (full) @(posedge clk);
    assemble_report(r);
  endtask

  // Drop push, wait for all words, then let queued empty reports drain
  task automatic settle();
    push <= 1'b0;
    while (scan_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_layout(input logic german);
    settle();
    cfg_write <= 1'b1;
    cfg_data <= german;
    @(posedge clk);
    cfg_write <= 1'b0;
    layout_german = german;
  endtask

  function automatic report_t make_report(input logic [7:0] mods, input logic [3:0] nbytes,
                                          input logic [7:0] a, b, c, d, e, f, g, h);
    report_t r;
    r.mods = mods;
    r.nbytes = nbytes;
    r.keys = {h, g, f, e, d, c, b, a};
    return r;
  endfunction

  // A keycode that prints in either layout and either shift state
  function automatic logic [7:0] printable_key();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(KC_SPACE, KC_SLASH));
    return 8'($urandom_range(KC_A, KC_0));
  endfunction

  // One report of a scan; the closing one carries Enter in a used slot
  function automatic report_t scan_report(input logic closing);
    report_t     r;
    int unsigned slot, roll, used;
    r.mods = 8'($urandom_range(0, 255));
    r.nbytes = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(3, 15))
                                           : 4'(MAX_REPORT_BYTES);
    for (slot = 0; slot < KEY_SLOTS; slot++) begin
      roll = $urandom_range(0, 19);
      if (roll < 2) r.keys[slot] = 8'h00;
      else if (roll == 2) r.keys[slot] = 8'($urandom_range(0, 255));
      else r.keys[slot] = printable_key();
    end
    if (closing) begin
      used = ((r.nbytes > MAX_REPORT_BYTES) ? MAX_REPORT_BYTES : r.nbytes) - FIRST_KEY_BYTE;
      r.keys[$urandom_range(0, used - 1)] = KC_ENTER;
    end
    return r;
  endfunction

  function automatic report_t noise_report();
    report_t     r;
    int unsigned slot;
    r.mods = 8'($urandom_range(0, 255));
    r.nbytes = 4'($urandom_range(0, 15));
    for (slot = 0; slot < KEY_SLOTS; slot++)
      r.keys[slot] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 63));
    return r;
  endfunction

  // Report lengths, unmapped keys, shift, both layouts and Enter handling
  task automatic test_report_decoding();
    // German layout out of reset; Enter with nothing held
    send_report(make_report(8'h00, 4'd3, KC_ENTER, KC_A, KC_A, KC_A, KC_A, KC_A, KC_A, KC_A));
    // short reports
    send_report(make_report(8'h00, 4'd0, KC_A, KC_A, KC_A, KC_A, KC_A, KC_A, KC_A, KC_A));
    send_report(make_report(8'h00, 4'd1, KC_B, KC_B, KC_B, KC_B, KC_B, KC_B, KC_B, KC_B));
    send_report(make_report(8'h00, 4'd2, KC_A, KC_A, KC_A, KC_A, KC_A, KC_A, KC_A, KC_A));
    // empty, out-of-range and non-printable keys only
    send_report(make_report(8'h00, 4'd10, 8'h00, KEYMAP_END, 8'hFF, 8'h80,
                            KC_ESC, KC_BKSP, KC_TAB, 8'h01));
    // left shift, German overrides and the y/z swap
    send_report(make_report(8'h02, 4'd10, 8'h02, 8'h03, KC_BKSP, KC_A,
                            KC_Y, KC_Z, KC_7, KC_COMMA));
    // right shift, Enter in mid report
    send_report(make_report(8'h20, 4'd10, KC_PERIOD, KC_1, KC_0, KC_MINUS,
                            KC_SLASH, KC_SPACE, KC_ENTER, KC_B));
    // no shift with other modifier bits, long report, double Enter
    send_report(make_report(8'hDD, 4'd15, KC_Y, KC_Z, KC_7, KC_COMMA,
                            KC_PERIOD, KC_ENTER, KC_ENTER, KC_X));
    send_report(make_report(8'hFF, 4'd11, KC_BSLASH, 8'd50, 8'd51, 8'd52,
                            8'd53, KC_MINUS, 8'd46, 8'd47));
    send_report(make_report(8'h00, 4'd13, KC_RBRACE, KC_BSLASH, 8'd50, 8'd51,
                            8'd52, 8'd53, KC_SLASH, KC_ENTER));
    // lengths that cut the slot list short or run past it
    send_report(make_report(8'h00, 4'd4, KC_A, KC_B, KC_X, KC_X, KC_X, KC_X, KC_X, KC_X));
    send_report(make_report(8'h00, 4'd9, KC_A, KC_B, KC_Y, KC_Z, KC_1, KC_7, KC_0, KC_X));
    send_report(make_report(8'h22, 4'd12, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                            8'hFF, 8'hFF, 8'hFF, KC_ENTER));
    // US layout: no swap, no overrides
    write_layout(LAYOUT_US);
    send_report(make_report(8'h02, 4'd10, KC_Y, KC_Z, KC_7, KC_COMMA,
                            KC_PERIOD, KC_BKSP, KC_ESC, KC_ENTER));
    send_report(make_report(8'h00, 4'd10, KC_Y, KC_Z, KC_7, KC_COMMA,
                            KC_PERIOD, KC_BKSP, 8'hFF, 8'h00));
    send_report(make_report(8'h00, 4'd14, KC_ENTER, KC_ENTER, KC_SPACE, KC_ENTER,
                            KC_ENTER, KC_TAB, KC_0, KC_ENTER));
    write_layout(LAYOUT_GERMAN);
  endtask

  // Fill the scan buffer past its limit, then close the scan
  task automatic test_buffer_full();
    report_t     r;
    int unsigned n, slot;
    send_report(make_report(8'h00, 4'd3, KC_ENTER, 8'h00, 8'h00, 8'h00,
                            8'h00, 8'h00, 8'h00, 8'h00));
    for (n = 0; n < 34; n++) begin
      r.mods = 8'h00;
      r.nbytes = 4'(MAX_REPORT_BYTES);
      for (slot = 0; slot < KEY_SLOTS; slot++)
        r.keys[slot] = 8'($urandom_range(KC_A, KC_Z));
      send_report(r);
    end
    send_report(make_report(8'h22, 4'd10, KC_ENTER, KC_A, KC_1, KC_ENTER,
                            KC_SPACE, KC_7, KC_COMMA, KC_PERIOD));
  endtask

  // Mostly well-formed scans with random content, plus noise reports
  task automatic test_random_scans(input logic german, input int unsigned count);
    int unsigned sent, i, burst;
    report_t     r;
    write_layout(german);
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 3) == 0) begin
        r = noise_report();
        send_report(r);
        if (r.nbytes >= 3) sent++;
      end else begin
        burst = $urandom_range(1, 5);
        for (i = 0; i < burst; i++) begin
          send_report(scan_report(i == burst - 1));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    push_idle_pct = 17;
    pop_idle_pct = 58;
    test_report_decoding();
    test_buffer_full();
    test_random_scans(LAYOUT_US, 89);
    push_idle_pct = 58;
    pop_idle_pct = 17;
    test_random_scans(LAYOUT_GERMAN, 89);
    push_idle_pct = 0;
    pop_idle_pct = 0;
    test_random_scans(LAYOUT_US, 88);
    settle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/hkba_pkg.sv
rtl/hkba_front.sv
rtl/hkba_back.sv
rtl/hkba_out_fifo.sv
rtl/hid_keyboard_barcode_assembler.sv
test/tb.sv
